[src/pms_pkg.sv]
`timescale 1ns / 1ps

package pms_pkg;

  localparam int TickW = 24;
  localparam int MvW   = 13;
  localparam int CfgW  = 24;
  localparam int IdxW  = 3;

  localparam logic [IdxW-1:0] REG_IDLE_TIMEOUT  = 3'd0;
  localparam logic [IdxW-1:0] REG_FEEDBACK      = 3'd1;
  localparam logic [IdxW-1:0] REG_LINGER        = 3'd2;
  localparam logic [IdxW-1:0] REG_SHOW_BATTERY  = 3'd3;
  localparam logic [IdxW-1:0] REG_BATTERY_CHECK = 3'd4;
  localparam logic [IdxW-1:0] REG_BATTERY_FULL  = 3'd5;
  localparam logic [IdxW-1:0] REG_BATTERY_MIN   = 3'd6;

  localparam logic [3:0] IND_DISCONNECTED  = 4'd0;
  localparam logic [3:0] IND_CONNECTED     = 4'd1;
  localparam logic [3:0] IND_SCANNING      = 4'd2;
  localparam logic [3:0] IND_READY         = 4'd3;
  localparam logic [3:0] IND_TX            = 4'd4;
  localparam logic [3:0] IND_RX            = 4'd5;
  localparam logic [3:0] IND_DUPLEX        = 4'd6;
  localparam logic [3:0] IND_ACTION        = 4'd7;
  localparam logic [3:0] IND_SHUTDOWN      = 4'd8;
  localparam logic [3:0] IND_BATT_SHUTDOWN = 4'd9;
  localparam logic [3:0] IND_FULL          = 4'd10;
  localparam logic [3:0] IND_LOW           = 4'd11;

  localparam logic [1:0] CAUSE_USER    = 2'd0;
  localparam logic [1:0] CAUSE_IDLE    = 2'd1;
  localparam logic [1:0] CAUSE_BATTERY = 2'd2;

  localparam logic [TickW-1:0] RST_IDLE_TIMEOUT  = 24'd300000;
  localparam logic [15:0]      RST_FEEDBACK      = 16'd2000;
  localparam logic [15:0]      RST_LINGER        = 16'd2000;
  localparam logic [15:0]      RST_SHOW_BATTERY  = 16'd3000;
  localparam logic [TickW-1:0] RST_BATTERY_CHECK = 24'd180000;
  localparam logic [MvW-1:0]   RST_BATTERY_FULL  = 13'd3750;
  localparam logic [MvW-1:0]   RST_BATTERY_MIN   = 13'd3500;

  typedef struct packed {
    logic           link_ready;
    logic           link_connected;
    logic           link_discovering;
    logic           tx_active;
    logic           rx_active;
    logic           usb_power;
    logic [MvW-1:0] battery_mv;
    logic           short_press;
    logic           long_press;
    logic           reset_request;
  } pms_in_t;

  typedef struct packed {
    logic [3:0] indicator;
    logic [2:0] mode;
    logic       sleep_request;
    logic       reset_pulse;
  } pms_out_t;

endpackage

[src/power_mode_supervisor.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    in_data  (pms_in_t)
// out       output     out_valid/out_stall  out_data (pms_out_t)
// cfg       input      cfg_wr_en            cfg_index, cfg_data
//
// One tick per clock unless in_stall holds it: a transfer on in updates the mode state and loads
// the result register in the same cycle, so the sustained rate is one item per cycle without stalls.
// out_valid rises in the cycle after an input transfer, from the registered result.
// in_stall rises only while a result waits in the output register and out is stalled.
// rst is synchronous: mode idle, counters zero, registers at their defaults.

module power_mode_supervisor
  import pms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pms_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pms_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_INUSE    = 3'd1,
    MODE_FEEDBACK = 3'd2,
    MODE_SHUTDOWN = 3'd3,
    MODE_SHOWBAT  = 3'd4
  } mode_t;

  logic [TickW-1:0] idle_timeout_ticks;
  logic [15:0]      feedback_ticks;
  logic [15:0]      linger_ticks;
  logic [15:0]      show_battery_ticks;
  logic [TickW-1:0] battery_check_ticks;
  logic [MvW-1:0]   battery_full_mv;
  logic [MvW-1:0]   battery_min_mv;

  mode_t            cur_mode, cur_mode_next;
  logic [TickW-1:0] ticks_in_mode, ticks_in_mode_next;
  logic [TickW-1:0] ticks_since_check, ticks_since_check_next;
  logic [1:0]       stop_cause, stop_cause_next;
  logic [3:0]       ind, ind_next;
  logic             sleep_next, pulse_next;

  logic             in_accept;
  logic             in_fb;
  logic             moved;
  logic [TickW-1:0] tsc_inc, tim_inc;
  logic [3:0]       showbat_ind;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    in_fb       = (cur_mode == MODE_FEEDBACK);
    showbat_ind = (in_data.battery_mv > battery_full_mv) ? IND_FULL : IND_LOW;
    tsc_inc     = (&ticks_since_check) ? ticks_since_check : ticks_since_check + 1'b1;
    tim_inc     = (&ticks_in_mode) ? ticks_in_mode : ticks_in_mode + 1'b1;

    cur_mode_next          = cur_mode;
    ticks_in_mode_next     = ticks_in_mode;
    ticks_since_check_next = tsc_inc;
    stop_cause_next        = stop_cause;
    ind_next               = ind;
    sleep_next             = 1'b0;
    pulse_next             = 1'b0;
    moved                  = 1'b0;

    if (!in_fb) begin
      if (in_data.short_press && cur_mode == MODE_IDLE) begin
        cur_mode_next      = MODE_SHOWBAT;
        ticks_in_mode_next = '0;
        ind_next           = showbat_ind;
        moved              = 1'b1;
      end
      if (in_data.long_press) begin
        stop_cause_next    = CAUSE_USER;
        cur_mode_next      = MODE_FEEDBACK;
        ticks_in_mode_next = '0;
        ind_next           = IND_ACTION;
        moved              = 1'b1;
      end
      if (tsc_inc > battery_check_ticks) begin
        ticks_since_check_next = '0;
        if (in_data.battery_mv < battery_min_mv) begin
          stop_cause_next    = CAUSE_BATTERY;
          cur_mode_next      = MODE_SHUTDOWN;
          ticks_in_mode_next = '0;
          ind_next           = IND_BATT_SHUTDOWN;
          moved              = 1'b1;
        end
      end
    end

    if (!moved) begin
      ticks_in_mode_next = tim_inc;
      unique case (cur_mode)
        MODE_IDLE: begin
          if (in_data.link_ready) begin
            cur_mode_next      = MODE_INUSE;
            ticks_in_mode_next = '0;
            ind_next           = IND_READY;
          end else begin
            if (in_data.link_connected)        ind_next = IND_CONNECTED;
            else if (in_data.link_discovering) ind_next = IND_SCANNING;
            else                               ind_next = IND_DISCONNECTED;
            if (tim_inc > idle_timeout_ticks) begin
              ticks_in_mode_next = '0;
              if (in_data.usb_power) begin
                ind_next = IND_DISCONNECTED;
              end else begin
                stop_cause_next = CAUSE_IDLE;
                cur_mode_next   = MODE_SHUTDOWN;
                ind_next        = IND_SHUTDOWN;
              end
            end
          end
          if (in_data.reset_request) begin
            pulse_next         = 1'b1;
            cur_mode_next      = MODE_IDLE;
            ticks_in_mode_next = '0;
            ind_next           = IND_DISCONNECTED;
          end
        end
        MODE_INUSE: begin
          if (!in_data.link_ready) begin
            cur_mode_next      = MODE_IDLE;
            ticks_in_mode_next = '0;
            ind_next           = IND_DISCONNECTED;
          end else if (in_data.tx_active && in_data.rx_active) begin
            ind_next = IND_DUPLEX;
          end else if (in_data.rx_active) begin
            ind_next = IND_RX;
          end else if (in_data.tx_active) begin
            ind_next = IND_TX;
          end else begin
            ind_next = IND_READY;
          end
        end
        MODE_FEEDBACK: begin
          if (tim_inc >= {8'd0, feedback_ticks}) begin
            cur_mode_next      = MODE_SHUTDOWN;
            ticks_in_mode_next = '0;
            ind_next = (stop_cause == CAUSE_BATTERY) ? IND_BATT_SHUTDOWN : IND_SHUTDOWN;
          end
        end
        MODE_SHUTDOWN: begin
          sleep_next = (tim_inc > {8'd0, linger_ticks});
        end
        MODE_SHOWBAT: begin
          if (tim_inc >= {8'd0, show_battery_ticks}) begin
            cur_mode_next      = MODE_IDLE;
            ticks_in_mode_next = '0;
            ind_next           = IND_DISCONNECTED;
          end
        end
        default: begin
          cur_mode_next = cur_mode;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks  <= RST_IDLE_TIMEOUT;
      feedback_ticks      <= RST_FEEDBACK;
      linger_ticks        <= RST_LINGER;
      show_battery_ticks  <= RST_SHOW_BATTERY;
      battery_check_ticks <= RST_BATTERY_CHECK;
      battery_full_mv     <= RST_BATTERY_FULL;
      battery_min_mv      <= RST_BATTERY_MIN;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT:  idle_timeout_ticks  <= cfg_data[TickW-1:0];
        REG_FEEDBACK:      feedback_ticks      <= cfg_data[15:0];
        REG_LINGER:        linger_ticks        <= cfg_data[15:0];
        REG_SHOW_BATTERY:  show_battery_ticks  <= cfg_data[15:0];
        REG_BATTERY_CHECK: battery_check_ticks <= cfg_data[TickW-1:0];
        REG_BATTERY_FULL:  battery_full_mv     <= cfg_data[MvW-1:0];
        REG_BATTERY_MIN:   battery_min_mv      <= cfg_data[MvW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode          <= MODE_IDLE;
      ticks_in_mode     <= '0;
      ticks_since_check <= '0;
      stop_cause        <= CAUSE_USER;
      ind               <= IND_DISCONNECTED;
      out_valid         <= 1'b0;
    end else begin
      if (in_accept) begin
        cur_mode               <= cur_mode_next;
        ticks_in_mode          <= ticks_in_mode_next;
        ticks_since_check      <= ticks_since_check_next;
        stop_cause             <= stop_cause_next;
        ind                    <= ind_next;
        out_valid              <= 1'b1;
        out_data.indicator     <= ind_next;
        out_data.mode          <= cur_mode_next;
        out_data.sleep_request <= sleep_next;
        out_data.reset_pulse   <= pulse_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sleep_in_shutdown: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sleep_request |-> out_data.mode == MODE_SHUTDOWN)
    else $error("sleep request outside shutdown");

  a_pulse_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reset_pulse |->
      out_data.mode == MODE_IDLE && out_data.indicator == IND_DISCONNECTED)
    else $error("reset pulse without return to idle");

  a_feedback_ind: assert property (@(posedge clk) disable iff (rst)
    cur_mode == MODE_FEEDBACK |-> ind == IND_ACTION)
    else $error("feedback mode with wrong indicator");

  a_shutdown_ind: assert property (@(posedge clk) disable iff (rst)
    cur_mode == MODE_SHUTDOWN |-> ind == IND_SHUTDOWN || ind == IND_BATT_SHUTDOWN)
    else $error("shutdown mode with wrong indicator");

  a_feedback_exit: assert property (@(posedge clk) disable iff (rst)
    in_accept && cur_mode == MODE_FEEDBACK |=>
      cur_mode == MODE_FEEDBACK || cur_mode == MODE_SHUTDOWN)
    else $error("feedback left for a mode other than shutdown");

endmodule

[test/power_mode_supervisor_tb.sv]
`timescale 1ns / 1ps

module power_mode_supervisor_tb;
  import pms_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_IN_USE       = 3'd1,
    MODE_FEEDBACK     = 3'd2,
    MODE_SHUTDOWN     = 3'd3,
    MODE_SHOW_BATTERY = 3'd4
  } sup_mode_e;

  localparam int MvMax = 5000;
  localparam int TickMax = 16777215;
  localparam logic [TickW-1:0] TickSat = '1;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 120;
  localparam int IdlePct = 23;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  pms_in_t         in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  pms_out_t        out_data;
  logic            cfg_wr_en = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  power_mode_supervisor uut (.*);

  // register copies
  logic [TickW-1:0] lim_idle = RST_IDLE_TIMEOUT;
  logic [15:0]      lim_feedback = RST_FEEDBACK;
  logic [15:0]      lim_linger = RST_LINGER;
  logic [15:0]      lim_show = RST_SHOW_BATTERY;
  logic [TickW-1:0] lim_check = RST_BATTERY_CHECK;
  logic [MvW-1:0]   full_mv = RST_BATTERY_FULL;
  logic [MvW-1:0]   min_mv = RST_BATTERY_MIN;

  // supervisor state
  sup_mode_e        sup_mode = MODE_IDLE;
  logic [TickW-1:0] dwell_ticks = '0;
  logic [TickW-1:0] check_ticks = '0;
  logic [1:0]       halt_cause = CAUSE_USER;
  logic [3:0]       led_code = IND_DISCONNECTED;
  logic             mode_changed = 1'b0;

  pms_in_t  tick_queue[$];
  pms_out_t status_queue[$];

  int ticks_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int sleeps_seen = 0;
  int pulses_seen = 0;
  int settings_used = 0;
  int send_gap_pct = IdlePct;
  int recv_stall_pct = IdlePct;
  int hold_left = 0;
  int cycles = 0;
  bit squeeze_armed = 1'b0;
  bit squeeze_done = 1'b0;
  bit link_up = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void enter_mode(sup_mode_e m, logic [MvW-1:0] mv);
    sup_mode = m;
    dwell_ticks = '0;
    mode_changed = 1'b1;
    case (m)
      MODE_IDLE:     led_code = IND_DISCONNECTED;
      MODE_IN_USE:   led_code = IND_READY;
      MODE_FEEDBACK: led_code = IND_ACTION;
      MODE_SHUTDOWN: led_code = (halt_cause == CAUSE_BATTERY) ? IND_BATT_SHUTDOWN : IND_SHUTDOWN;
      default:       led_code = (mv > full_mv) ? IND_FULL : IND_LOW;
    endcase
  endfunction

  function automatic pms_out_t step_supervisor(pms_in_t t);
    pms_out_t r;
    logic     frozen;
    r = '0;
    frozen = (sup_mode == MODE_FEEDBACK);
    mode_changed = 1'b0;
    if (!frozen) begin
      if (t.short_press && sup_mode == MODE_IDLE) enter_mode(MODE_SHOW_BATTERY, t.battery_mv);
      if (t.long_press) begin
        halt_cause = CAUSE_USER;
        enter_mode(MODE_FEEDBACK, t.battery_mv);
      end
    end
    if (check_ticks != TickSat) check_ticks++;
    if (!frozen && check_ticks > lim_check) begin
      check_ticks = '0;
      if (t.battery_mv < min_mv) begin
        halt_cause = CAUSE_BATTERY;
        enter_mode(MODE_SHUTDOWN, t.battery_mv);
      end
    end
    if (!mode_changed) begin
      if (dwell_ticks != TickSat) dwell_ticks++;
      case (sup_mode)
        MODE_IDLE: begin
          if (t.link_ready) enter_mode(MODE_IN_USE, t.battery_mv);
          else if (t.link_connected) led_code = IND_CONNECTED;
          else if (t.link_discovering) led_code = IND_SCANNING;
          else led_code = IND_DISCONNECTED;
          if (sup_mode == MODE_IDLE && dwell_ticks > lim_idle) begin
            if (t.usb_power) begin
              enter_mode(MODE_IDLE, t.battery_mv);
            end else begin
              halt_cause = CAUSE_IDLE;
              enter_mode(MODE_SHUTDOWN, t.battery_mv);
            end
          end
          if (t.reset_request) begin
            r.reset_pulse = 1'b1;
            enter_mode(MODE_IDLE, t.battery_mv);
          end
        end
        MODE_IN_USE: begin
          if (!t.link_ready) enter_mode(MODE_IDLE, t.battery_mv);
          else if (t.tx_active && t.rx_active) led_code = IND_DUPLEX;
          else if (t.rx_active) led_code = IND_RX;
          else if (t.tx_active) led_code = IND_TX;
          else led_code = IND_READY;
        end
        MODE_FEEDBACK: begin
          if (dwell_ticks >= lim_feedback) enter_mode(MODE_SHUTDOWN, t.battery_mv);
        end
        MODE_SHUTDOWN: begin
          r.sleep_request = (dwell_ticks > lim_linger);
        end
        default: begin
          if (dwell_ticks >= lim_show) enter_mode(MODE_IDLE, t.battery_mv);
        end
      endcase
    end
    r.indicator = led_code;
    r.mode = sup_mode;
    return r;
  endfunction

  // link_bits: ready, connected, discovering, tx, rx, usb; press_bits: short, long, reset
  function automatic void queue_tick(logic [5:0] link_bits, int mv, logic [2:0] press_bits);
    tick_queue.push_back(pms_in_t'({link_bits, MvW'(mv), press_bits}));
  endfunction

  function automatic pms_in_t make_tick(int short_pct, int long_pct, bit usb_held);
    pms_in_t t;
    int      mv;
    if ($urandom_range(99) < 8) link_up = !link_up;
    case ($urandom_range(9))
      0:       mv = 0;
      1:       mv = MvMax;
      2:       mv = int'(full_mv) + int'($urandom_range(4)) - 2;
      3:       mv = int'(min_mv) + int'($urandom_range(4)) - 2;
      default: mv = int'($urandom_range(MvMax));
    endcase
    if (mv < 0) mv = 0;
    if (mv > MvMax) mv = MvMax;
    t.link_ready = link_up;
    t.link_connected = 1'($urandom_range(1));
    t.link_discovering = 1'($urandom_range(1));
    t.tx_active = 1'($urandom_range(1));
    t.rx_active = 1'($urandom_range(1));
    t.usb_power = usb_held | 1'($urandom_range(1));
    t.battery_mv = MvW'(mv);
    t.short_press = ($urandom_range(99) < short_pct);
    t.long_press = ($urandom_range(99) < long_pct);
    t.reset_request = ($urandom_range(99) < 3);
    return t;
  endfunction

  task automatic write_reg(logic [IdxW-1:0] idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgW'(val);
    case (idx)
      REG_IDLE_TIMEOUT:  lim_idle = TickW'(val);
      REG_FEEDBACK:      lim_feedback = 16'(val);
      REG_LINGER:        lim_linger = 16'(val);
      REG_SHOW_BATTERY:  lim_show = 16'(val);
      REG_BATTERY_CHECK: lim_check = TickW'(val);
      REG_BATTERY_FULL:  full_mv = MvW'(val);
      REG_BATTERY_MIN:   min_mv = MvW'(val);
      default: ;
    endcase
  endtask

  task automatic program_regs(int idle, int fb, int linger, int show, int check, int full,
                              int low);
    write_reg(REG_IDLE_TIMEOUT, idle);
    write_reg(REG_FEEDBACK, fb);
    write_reg(REG_LINGER, linger);
    write_reg(REG_SHOW_BATTERY, show);
    write_reg(REG_BATTERY_CHECK, check);
    write_reg(REG_BATTERY_FULL, full);
    write_reg(REG_BATTERY_MIN, low);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || status_queue.size() != 0);
  endtask

  task automatic run_phase(int count, int short_pct, int long_pct, bit usb_held);
    repeat (count) tick_queue.push_back(make_tick(short_pct, long_pct, usb_held));
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_queue.push_back(step_supervisor(in_data));
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data <= tick_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    pms_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.sleep_request) sleeps_seen++;
        if (out_data.reset_pulse) pulses_seen++;
        if (status_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: transfer with nothing expected (indicator %0d mode %0d)",
                     results_seen, out_data.indicator, out_data.mode);
        end else begin
          want = status_queue.pop_front();
          if (out_data.indicator !== want.indicator || out_data.mode !== want.mode ||
              out_data.sleep_request !== want.sleep_request ||
              out_data.reset_pulse !== want.reset_pulse) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: indicator %0d/%0d mode %0d/%0d sleep %0b/%0b reset %0b/%0b",
                       results_seen, want.indicator, out_data.indicator, want.mode,
                       out_data.mode, want.sleep_request, out_data.sleep_request,
                       want.reset_pulse, out_data.reset_pulse);
          end
        end
      end
      if (hold_left == 0 && squeeze_armed && !squeeze_done) begin
        hold_left = HoldCycles;
        squeeze_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_tick(6'b000000, 0, 3'b000);
    queue_tick(6'b001000, 5000, 3'b000);
    queue_tick(6'b011001, 4095, 3'b000);
    queue_tick(6'b010000, 1, 3'b001);
    queue_tick(6'b100000, 3500, 3'b000);
    queue_tick(6'b100100, 3499, 3'b000);
    queue_tick(6'b100010, 3751, 3'b000);
    queue_tick(6'b111111, 5000, 3'b101);
    queue_tick(6'b100000, 2048, 3'b000);
    queue_tick(6'b000110, 0, 3'b000);
    queue_tick(6'b000001, 3750, 3'b100);
    queue_tick(6'b110000, 5000, 3'b101);
    queue_tick(6'b000000, 3751, 3'b000);
    drain();

    program_regs($urandom_range(60, 5), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(20), $urandom_range(40, 1), $urandom_range(MvMax), 0);
    run_phase(400, 6, 0, 1'b1);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    program_regs(1, 0, 0, 0, 1, 0, 0);
    queue_tick(6'b000001, 5000, 3'b100);
    run_phase(150, 8, 0, 1'b1);
    send_gap_pct = IdlePct;
    recv_stall_pct = IdlePct;

    program_regs(TickMax, 65535, 65535, 65535, TickMax, MvMax, MvMax);
    run_phase(150, 2, 0, 1'b0);

    program_regs($urandom_range(80, 2), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(30), $urandom_range(100, 1), $urandom_range(MvMax), 0);
    squeeze_armed = 1'b1;
    run_phase(400, 5, 0, 1'b1);

    // idle timeout on battery, then a zero-length feedback
    program_regs(12, 0, 3, 4, 25, 3750, 3500);
    repeat (30) queue_tick(6'b000000, 4000, 3'b000);
    queue_tick(6'b000000, 4000, 3'b010);
    run_phase(250, 5, 4, 1'b0);

    program_regs(TickMax, $urandom_range(15, 2), $urandom_range(10), $urandom_range(65535),
                 $urandom_range(20, 1), $urandom_range(MvMax), $urandom_range(MvMax, 2000));
    run_phase(250, 5, 5, 1'b0);

    repeat (4) @(posedge clk);
    mismatches += status_queue.size();
    $display("Checked %0d status results from %0d ticks across %0d register settings.",
             results_seen, ticks_sent, settings_used);
    $display("Saw %0d sleep requests and %0d reset pulses; %0d mismatches.",
             sleeps_seen, pulses_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
